FILE: rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg: request frame decoder shared types
// Phase codes, byte role codes and the per-byte result word.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned HalfW = 16;
  localparam int unsigned RoleW = 3;

  // Parser phase; codes above PH_VAL are unused and read as PH_OPCODE
  typedef enum logic [3:0] {
    PH_OPCODE  = 4'd0,
    PH_CNT_LO  = 4'd1,
    PH_CNT_HI  = 4'd2,
    PH_KLEN_LO = 4'd3,
    PH_KLEN_HI = 4'd4,
    PH_VLEN_LO = 4'd5,
    PH_VLEN_HI = 4'd6,
    PH_KEY     = 4'd7,
    PH_VAL     = 4'd8
  } phase_t;

  typedef enum logic [RoleW-1:0] {
    ROLE_OPCODE = 3'd0,
    ROLE_COUNT  = 3'd1,
    ROLE_KLEN   = 3'd2,
    ROLE_VLEN   = 3'd3,
    ROLE_KEY    = 3'd4,
    ROLE_VALUE  = 3'd5
  } role_t;

  typedef struct packed {
    logic [ByteW-1:0] opcode;
    role_t            byte_role;
    logic [ByteW-1:0] echo_byte;
    logic [HalfW-1:0] item_index;
    logic [HalfW-1:0] key_length;
    logic [HalfW-1:0] value_length;
    logic [HalfW-1:0] field_position;
    logic             item_end;
    logic             message_end;
  } result_t;

endpackage

FILE: rtl/rfd_parser.sv
// ----------------------------------------------------------------------------
// rfd_parser: request frame phase machine
// Holds the parse state and tags one byte per step.
// ----------------------------------------------------------------------------
module rfd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [rfd_pkg::ByteW-1:0]  data_byte,
  output rfd_pkg::result_t           result
);

  rfd_pkg::phase_t             phase_r, phase_nxt;
  logic [rfd_pkg::ByteW-1:0]   opcode_r, opcode_nxt;
  logic [rfd_pkg::HalfW-1:0]   items_left_r, items_left_nxt;
  logic [rfd_pkg::HalfW-1:0]   item_cnt_r, item_cnt_nxt;
  logic [rfd_pkg::HalfW-1:0]   key_len_r, key_len_nxt;
  logic [rfd_pkg::HalfW-1:0]   val_len_r, val_len_nxt;
  logic [rfd_pkg::HalfW-1:0]   field_pos_r, field_pos_nxt;

  logic [rfd_pkg::HalfW-1:0]   items_dec;
  logic [rfd_pkg::HalfW-1:0]   pos_inc;
  logic                        last_item;

  assign items_dec = items_left_r - 16'd1;
  assign last_item = (items_dec == '0);
  assign pos_inc   = field_pos_r + 16'd1;

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    opcode_nxt     = opcode_r;
    items_left_nxt = items_left_r;
    item_cnt_nxt   = item_cnt_r;
    key_len_nxt    = key_len_r;
    val_len_nxt    = val_len_r;
    field_pos_nxt  = field_pos_r;
    case (phase_r)
      rfd_pkg::PH_CNT_LO: begin
        items_left_nxt = {8'd0, data_byte};
        phase_nxt      = rfd_pkg::PH_CNT_HI;
      end
      rfd_pkg::PH_CNT_HI: begin
        items_left_nxt = {data_byte, items_left_r[7:0]};
        item_cnt_nxt   = '0;
        phase_nxt      = ({data_byte, items_left_r[7:0]} == '0) ?
                         rfd_pkg::PH_OPCODE : rfd_pkg::PH_KLEN_LO;
      end
      rfd_pkg::PH_KLEN_LO: begin
        key_len_nxt = {8'd0, data_byte};
        val_len_nxt = '0;
        phase_nxt   = rfd_pkg::PH_KLEN_HI;
      end
      rfd_pkg::PH_KLEN_HI: begin
        key_len_nxt = {data_byte, key_len_r[7:0]};
        phase_nxt   = rfd_pkg::PH_VLEN_LO;
      end
      rfd_pkg::PH_VLEN_LO: begin
        val_len_nxt = {8'd0, data_byte};
        phase_nxt   = rfd_pkg::PH_VLEN_HI;
      end
      rfd_pkg::PH_VLEN_HI: begin
        val_len_nxt   = {data_byte, val_len_r[7:0]};
        field_pos_nxt = '0;
        if (key_len_r != '0) begin
          phase_nxt = rfd_pkg::PH_KEY;
        end else if ({data_byte, val_len_r[7:0]} != '0) begin
          phase_nxt = rfd_pkg::PH_VAL;
        end else begin
          items_left_nxt = items_dec;
          if (last_item) begin
            phase_nxt = rfd_pkg::PH_OPCODE;
          end else begin
            item_cnt_nxt = item_cnt_r + 16'd1;
            phase_nxt    = rfd_pkg::PH_KLEN_LO;
          end
        end
      end
      rfd_pkg::PH_KEY: begin
        field_pos_nxt = pos_inc;
        if (pos_inc == key_len_r) begin
          field_pos_nxt = '0;
          if (val_len_r != '0) begin
            phase_nxt = rfd_pkg::PH_VAL;
          end else begin
            items_left_nxt = items_dec;
            if (last_item) begin
              phase_nxt = rfd_pkg::PH_OPCODE;
            end else begin
              item_cnt_nxt = item_cnt_r + 16'd1;
              phase_nxt    = rfd_pkg::PH_KLEN_LO;
            end
          end
        end
      end
      rfd_pkg::PH_VAL: begin
        field_pos_nxt = pos_inc;
        if (pos_inc == val_len_r) begin
          field_pos_nxt  = '0;
          items_left_nxt = items_dec;
          if (last_item) begin
            phase_nxt = rfd_pkg::PH_OPCODE;
          end else begin
            item_cnt_nxt = item_cnt_r + 16'd1;
            phase_nxt    = rfd_pkg::PH_KLEN_LO;
          end
        end
      end
      default: begin
        opcode_nxt     = data_byte;
        items_left_nxt = '0;
        item_cnt_nxt   = '0;
        key_len_nxt    = '0;
        val_len_nxt    = '0;
        field_pos_nxt  = '0;
        phase_nxt      = rfd_pkg::PH_CNT_LO;
      end
    endcase
  end

  // outputs
  always_comb begin
    result                = '0;
    result.opcode         = opcode_nxt;
    result.echo_byte      = data_byte;
    result.byte_role      = rfd_pkg::ROLE_OPCODE;
    case (phase_r)
      rfd_pkg::PH_CNT_LO: begin
        result.byte_role = rfd_pkg::ROLE_COUNT;
      end
      rfd_pkg::PH_CNT_HI: begin
        result.byte_role   = rfd_pkg::ROLE_COUNT;
        result.message_end = ({data_byte, items_left_r[7:0]} == '0);
      end
      rfd_pkg::PH_KLEN_LO: begin
        result.byte_role  = rfd_pkg::ROLE_KLEN;
        result.item_index = item_cnt_r;
      end
      rfd_pkg::PH_KLEN_HI: begin
        result.byte_role  = rfd_pkg::ROLE_KLEN;
        result.item_index = item_cnt_r;
        result.key_length = key_len_nxt;
      end
      rfd_pkg::PH_VLEN_LO: begin
        result.byte_role  = rfd_pkg::ROLE_VLEN;
        result.item_index = item_cnt_r;
        result.key_length = key_len_r;
      end
      rfd_pkg::PH_VLEN_HI: begin
        result.byte_role    = rfd_pkg::ROLE_VLEN;
        result.item_index   = item_cnt_r;
        result.key_length   = key_len_r;
        result.value_length = val_len_nxt;
        if (key_len_r == '0 && val_len_nxt == '0) begin
          result.item_end    = 1'b1;
          result.message_end = last_item;
        end
      end
      rfd_pkg::PH_KEY: begin
        result.byte_role      = rfd_pkg::ROLE_KEY;
        result.item_index     = item_cnt_r;
        result.key_length     = key_len_r;
        result.value_length   = val_len_r;
        result.field_position = field_pos_r;
        if (pos_inc == key_len_r && val_len_r == '0) begin
          result.item_end    = 1'b1;
          result.message_end = last_item;
        end
      end
      rfd_pkg::PH_VAL: begin
        result.byte_role      = rfd_pkg::ROLE_VALUE;
        result.item_index     = item_cnt_r;
        result.key_length     = key_len_r;
        result.value_length   = val_len_r;
        result.field_position = field_pos_r;
        if (pos_inc == val_len_r) begin
          result.item_end    = 1'b1;
          result.message_end = last_item;
        end
      end
      default: begin
        result.byte_role = rfd_pkg::ROLE_OPCODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rfd_pkg::PH_OPCODE;
      opcode_r     <= '0;
      items_left_r <= '0;
      item_cnt_r   <= '0;
      key_len_r    <= '0;
      val_len_r    <= '0;
      field_pos_r  <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      opcode_r     <= opcode_nxt;
      items_left_r <= items_left_nxt;
      item_cnt_r   <= item_cnt_nxt;
      key_len_r    <= key_len_nxt;
      val_len_r    <= val_len_nxt;
      field_pos_r  <= field_pos_nxt;
    end
  end

endmodule

FILE: rtl/request_frame_decoder.sv
// ----------------------------------------------------------------------------
// request_frame_decoder: key-value request byte tagger
// Tags each byte of a request message with role, item, lengths and position.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | in_data_byte
//  out_    | out | out_valid/out_stall| opcode, role, byte, index, lengths, pos, ends
//
//  One word in, one word out, one word per cycle sustained while out_stall is low.
//  A word passes the input register, then parse logic into the result register.
//  The single phase machine is updated once per word.
//  rst_n (synchronous) returns the parser to expecting an opcode byte.
//  out_stall holds the result register; the input register keeps taking a word
//  until it is full too, then in_stall rises.
// ----------------------------------------------------------------------------
module request_frame_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  // input word channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rfd_pkg::ByteW-1:0]   in_data_byte,
  // result word channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rfd_pkg::ByteW-1:0]   out_opcode,
  output logic [rfd_pkg::RoleW-1:0]   out_byte_role,
  output logic [rfd_pkg::ByteW-1:0]   out_echo_byte,
  output logic [rfd_pkg::HalfW-1:0]   out_item_index,
  output logic [rfd_pkg::HalfW-1:0]   out_key_length,
  output logic [rfd_pkg::HalfW-1:0]   out_value_length,
  output logic [rfd_pkg::HalfW-1:0]   out_field_position,
  output logic                        out_item_end,
  output logic                        out_message_end
);

  // input register
  logic                       in_vld_r, in_vld_nxt;
  logic [rfd_pkg::ByteW-1:0]  in_byte_r;

  // result register
  logic                       out_vld_r, out_vld_nxt;
  rfd_pkg::result_t           res_r;
  rfd_pkg::result_t           res_nxt;

  logic out_free;   // result register can load this cycle
  logic step;       // word moves from input register to result register
  logic in_take;

  assign out_free = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign in_vld_nxt  = in_take || (in_vld_r && !step);
  assign out_vld_nxt = step || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  // phase machine, advanced once per word handed to the result register
  rfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .result    (res_nxt)
  );

  assign out_valid          = out_vld_r;
  assign out_opcode         = res_r.opcode;
  assign out_byte_role      = res_r.byte_role;
  assign out_echo_byte      = res_r.echo_byte;
  assign out_item_index     = res_r.item_index;
  assign out_key_length     = res_r.key_length;
  assign out_value_length   = res_r.value_length;
  assign out_field_position = res_r.field_position;
  assign out_item_end       = res_r.item_end;
  assign out_message_end    = res_r.message_end;

`ifndef SYNTHESIS
  // item end only on a value-length, key or value byte
  a_item_end_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.item_end) |->
      (res_r.byte_role == rfd_pkg::ROLE_VLEN || res_r.byte_role == rfd_pkg::ROLE_KEY ||
       res_r.byte_role == rfd_pkg::ROLE_VALUE))
    else $error("item end on wrong byte role");

  // message end without item end only on the item count byte
  a_msg_end_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.message_end && !res_r.item_end) |->
      (res_r.byte_role == rfd_pkg::ROLE_COUNT))
    else $error("message end without item end off count byte");

  // opcode bytes carry no item context
  a_opcode_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.byte_role == rfd_pkg::ROLE_OPCODE) |->
      (res_r.item_index == '0 && res_r.key_length == '0 &&
       res_r.field_position == '0 && !res_r.item_end && !res_r.message_end))
    else $error("opcode byte with item context");

  // input stall only while both registers are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled with free space");
`endif

endmodule
